// ----- src/oaht_pkg.sv -----
// Package for the open-addressing hash table: field widths, slot kinds,
// request codes and the command/status bundles between controller and datapath.
// No dependencies.
`default_nettype none

package oaht_pkg;

	localparam int TYPE_W = 2;
	localparam int KEY_W  = 32;
	localparam int HASH_W = 32;
	localparam int VAL_W  = 64;
	localparam int CFG_W  = 8;
	localparam int OCC_W  = 9;

	localparam logic [CFG_W-1:0] MAX_OCC_RESET = 8'd192;

	// request codes; the fourth code is unused and answers with all zeros
	localparam logic [TYPE_W-1:0] REQ_INSERT = 2'd0;
	localparam logic [TYPE_W-1:0] REQ_LOOKUP = 2'd1;
	localparam logic [TYPE_W-1:0] REQ_REMOVE = 2'd2;

	typedef enum logic [1:0] {
		KIND_EMPTY = 2'd0,
		KIND_LIVE  = 2'd1,
		KIND_TOMB  = 2'd2
	} kind_t;

	typedef struct packed {
		logic  in_ready;
		logic  clear_wr;
		logic  probe_init;
		logic  rd_en;
		logic  probe_adv;
		logic  note_tomb;
		logic  tgt_load;
		logic  tgt_tomb;
		logic  wr_en;
		kind_t wr_kind;
		logic  occ_inc;
		logic  res_load;
		logic  res_hit;
		logic  res_rej;
		logic  res_take_val;
	} cmd_t;

	typedef struct packed {
		logic              in_valid;
		logic              clear_last;
		logic              home_done;
		logic [TYPE_W-1:0] req_code;
		kind_t             rd_kind;
		logic              key_match;
		logic              probe_last;
		logic              have_tomb;
		logic              occ_full;
		logic              out_free;
	} sts_t;

endpackage

`default_nettype wire

// ----- src/oaht_if.sv -----
// Request and response channel interfaces of the hash table.
// Depends on oaht_pkg for the field widths.
`default_nettype none

interface oaht_req_if;
	import oaht_pkg::*;

	logic              valid;
	logic              ready;
	logic [TYPE_W-1:0] req_type;
	logic [KEY_W-1:0]  key_id;
	logic [HASH_W-1:0] key_hash;
	logic [VAL_W-1:0]  store_value;

	modport source (output valid, output req_type, output key_id, output key_hash,
		output store_value, input ready);
	modport sink (input valid, input req_type, input key_id, input key_hash,
		input store_value, output ready);
endinterface

interface oaht_rsp_if;
	import oaht_pkg::*;

	logic             valid;
	logic             ready;
	logic             hit;
	logic [VAL_W-1:0] value_out;
	logic             rejected;

	modport source (output valid, output hit, output value_out, output rejected,
		input ready);
	modport sink (input valid, input hit, input value_out, input rejected,
		output ready);
endinterface

`default_nettype wire

// ----- src/oaht_home.sv -----
// Home slot unit: key_hash modulo the slot count.
// A mask for a power-of-two count, else a pipelined reciprocal multiplication.
// Depends on oaht_pkg.
`default_nettype none

module oaht_home #(
	parameter int SLOTS = 256
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             start,
	input  wire  [oaht_pkg::HASH_W-1:0]     hash,
	output logic                            done,
	output logic [$clog2(SLOTS)-1:0]        home
);
	import oaht_pkg::*;

	localparam int IDX_W = $clog2(SLOTS);
	localparam bit POW2  = (SLOTS & (SLOTS - 1)) == 0;

	generate
		if (POW2) begin : g_mask
			logic             done_q;
			logic [IDX_W-1:0] home_q;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					done_q <= 1'b0;
				end else begin
					done_q <= start;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					home_q <= hash[IDX_W-1:0];
				end
			end

			assign done = done_q;
			assign home = home_q;
		end else begin : g_recip
			// quotient = (hash * RECIP) >> SH, exact for every hash value;
			// RECIP has its top bit at 2^HASH_W, so add the hash in shifted
			localparam int                SH       = HASH_W + IDX_W;
			localparam logic [63:0]       RECIP    = ((64'd1 << SH) / 64'(SLOTS)) + 64'd1;
			localparam logic [HASH_W-1:0] RECIP_LO = RECIP[HASH_W-1:0];
			localparam logic [IDX_W-1:0]  DIV      = IDX_W'(SLOTS);

			logic                v_s1, v_s2, done_q;
			logic [2*HASH_W-1:0] prod_s1;
			logic [HASH_W-1:0]   n_s1;
			logic [IDX_W-1:0]    q_s2, n_s2, home_q;
			logic [2*HASH_W:0]   sum;
			logic [2*IDX_W-1:0]  qd;

			assign sum = {1'b0, prod_s1} + {1'b0, n_s1, {HASH_W{1'b0}}};
			// only the low bits of quotient times count reach the remainder
			assign qd  = {{IDX_W{1'b0}}, q_s2} * {{IDX_W{1'b0}}, DIV};

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s1   <= 1'b0;
					v_s2   <= 1'b0;
					done_q <= 1'b0;
				end else begin
					v_s1   <= start;
					v_s2   <= v_s1;
					done_q <= v_s2;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					prod_s1 <= {{HASH_W{1'b0}}, hash} * {{HASH_W{1'b0}}, RECIP_LO};
					n_s1    <= hash;
				end
				if (v_s1) begin
					q_s2 <= sum[SH +: IDX_W];
					n_s2 <= n_s1[IDX_W-1:0];
				end
				if (v_s2) begin
					home_q <= n_s2 - qd[IDX_W-1:0];
				end
			end

			assign done = done_q;
			assign home = home_q;
		end
	endgenerate

endmodule

`default_nettype wire

// ----- src/oaht_ctrl.sv -----
// Controller of the hash table: clearing pass, probe sequencing and outcome.
// Drives cmd_t, reads sts_t; depends on oaht_pkg.
`default_nettype none

module oaht_ctrl (
	input  wire             clk,
	input  wire             arst_n,
	input  oaht_pkg::sts_t  sts,
	output oaht_pkg::cmd_t  cmd
);
	import oaht_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_HOME,
		S_READ,
		S_CHECK,
		S_DONE
	} state_t;

	typedef struct packed {
		logic  wr;
		kind_t kind;
		logic  hit;
		logic  rej;
		logic  take_val;
		logic  occ_inc;
	} outc_t;

	state_t state_q, state_d;
	outc_t  res_q, res_d;
	logic   is_ins, is_look, is_rem, free_empty;

	assign is_ins  = sts.req_code == REQ_INSERT;
	assign is_look = sts.req_code == REQ_LOOKUP;
	assign is_rem  = sts.req_code == REQ_REMOVE;
	assign free_empty = !sts.have_tomb;

	always_comb begin
		state_d = state_q;
		res_d   = res_q;
		cmd     = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear_wr = 1'b1;
				if (sts.clear_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				cmd.in_ready = 1'b1;
				res_d = '0;
				if (sts.in_valid) begin
					state_d = S_HOME;
				end
			end
			S_HOME: begin
				if (sts.home_done) begin
					if (is_ins || is_look || is_rem) begin
						cmd.probe_init = 1'b1;
						state_d = S_READ;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_READ: begin
				cmd.rd_en = 1'b1;
				state_d = S_CHECK;
			end
			S_CHECK: begin
				priority if (sts.rd_kind == KIND_LIVE && sts.key_match) begin
					// live match: update, read out or bury it
					cmd.tgt_load = 1'b1;
					res_d.hit = 1'b1;
					res_d.take_val = is_look;
					res_d.wr = is_ins || is_rem;
					res_d.kind = is_rem ? KIND_TOMB : KIND_LIVE;
					state_d = S_DONE;
				end else if (sts.rd_kind == KIND_LIVE || sts.rd_kind == KIND_TOMB) begin
					cmd.note_tomb = sts.rd_kind == KIND_TOMB;
					if (sts.probe_last) begin
						// chain exhausted: only a tombstone can take a new key
						cmd.tgt_load = 1'b1;
						cmd.tgt_tomb = 1'b1;
						if (sts.have_tomb || sts.rd_kind == KIND_TOMB) begin
							res_d.wr = is_ins;
							res_d.kind = KIND_LIVE;
						end else begin
							res_d.rej = is_ins;
						end
						state_d = S_DONE;
					end else begin
						cmd.probe_adv = 1'b1;
						state_d = S_READ;
					end
				end else begin
					// empty slot ends the search; reuse the first tombstone if any
					cmd.tgt_load = 1'b1;
					cmd.tgt_tomb = 1'b1;
					res_d.kind = KIND_LIVE;
					if (is_ins) begin
						if (free_empty && sts.occ_full) begin
							res_d.rej = 1'b1;
						end else begin
							res_d.wr = 1'b1;
							res_d.occ_inc = free_empty;
						end
					end
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.wr_en = res_q.wr;
					cmd.wr_kind = res_q.kind;
					cmd.occ_inc = res_q.occ_inc;
					cmd.res_load = 1'b1;
					cmd.res_hit = res_q.hit;
					cmd.res_rej = res_q.rej;
					cmd.res_take_val = res_q.take_val;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			res_q   <= '0;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
		end
	end

endmodule

`default_nettype wire

// ----- src/oaht_datapath.sv -----
// Datapath of the hash table: slot memory, probe registers, occupancy,
// limit register and the response register. Depends on oaht_pkg, oaht_if, oaht_home.
`default_nettype none

module oaht_datapath #(
	parameter int SLOTS = 256
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           cfg_we,
	input  wire  [oaht_pkg::CFG_W-1:0]    cfg_wdata,
	oaht_req_if.sink                      req,
	oaht_rsp_if.source                    rsp,
	input  oaht_pkg::cmd_t                cmd,
	output oaht_pkg::sts_t                sts
);
	import oaht_pkg::*;

	localparam int               IDX_W = $clog2(SLOTS);
	localparam logic [IDX_W-1:0] LAST  = IDX_W'(SLOTS - 1);

	typedef struct packed {
		kind_t            kind;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} slot_t;

	slot_t mem [SLOTS];
	slot_t rd_q;
	slot_t mem_wd;

	logic              accept;
	logic              home_done;
	logic [IDX_W-1:0]  home;
	logic [TYPE_W-1:0] type_q;
	logic [KEY_W-1:0]  key_q;
	logic [VAL_W-1:0]  val_q;
	logic [IDX_W-1:0]  idx_q, cnt_q, tomb_q, tgt_q, clr_q;
	logic [IDX_W-1:0]  mem_addr;
	logic              mem_we;
	logic              have_tomb_q;
	logic [OCC_W-1:0]  occ_q;
	logic [CFG_W-1:0]  max_q;
	logic              out_valid_q, out_hit_q, out_rej_q;
	logic [VAL_W-1:0]  out_val_q;

	assign req.ready = cmd.in_ready;
	assign accept    = req.valid && cmd.in_ready;

	oaht_home #(.SLOTS(SLOTS)) u_home (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.hash   (req.key_hash),
		.done   (home_done),
		.home   (home)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			occ_q       <= '0;
			max_q       <= MAX_OCC_RESET;
			have_tomb_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear_wr) begin
				clr_q <= (clr_q == LAST) ? '0 : clr_q + 1'b1;
			end
			if (cmd.occ_inc) begin
				occ_q <= occ_q + 1'b1;
			end
			if (cfg_we) begin
				max_q <= cfg_wdata;
			end
			if (cmd.probe_init) begin
				have_tomb_q <= 1'b0;
			end else if (cmd.note_tomb) begin
				have_tomb_q <= 1'b1;
			end
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			type_q <= req.req_type;
			key_q  <= req.key_id;
			val_q  <= req.store_value;
		end
		if (cmd.probe_init) begin
			idx_q <= home;
			cnt_q <= '0;
		end else if (cmd.probe_adv) begin
			idx_q <= (idx_q == LAST) ? '0 : idx_q + 1'b1;
			cnt_q <= cnt_q + 1'b1;
		end
		if (cmd.note_tomb && !have_tomb_q) begin
			tomb_q <= idx_q;
		end
		if (cmd.tgt_load) begin
			tgt_q <= (cmd.tgt_tomb && have_tomb_q) ? tomb_q : idx_q;
		end
		if (cmd.res_load) begin
			out_hit_q <= cmd.res_hit;
			out_rej_q <= cmd.res_rej;
			out_val_q <= cmd.res_take_val ? rd_q.value : '0;
		end
	end

	// slot memory: one write port, one registered read port
	always_comb begin
		mem_we   = cmd.clear_wr || cmd.wr_en;
		mem_addr = cmd.clear_wr ? clr_q : tgt_q;
		if (cmd.clear_wr) begin
			mem_wd = '{kind: KIND_EMPTY, key: '0, value: '0};
		end else if (cmd.wr_kind == KIND_TOMB) begin
			mem_wd = '{kind: KIND_TOMB, key: rd_q.key, value: rd_q.value};
		end else begin
			mem_wd = '{kind: KIND_LIVE, key: key_q, value: val_q};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wd;
		end
		if (cmd.rd_en) begin
			rd_q <= mem[idx_q];
		end
	end

	always_comb begin
		sts.in_valid   = req.valid;
		sts.clear_last = clr_q == LAST;
		sts.home_done  = home_done;
		sts.req_code   = type_q;
		sts.rd_kind    = rd_q.kind;
		sts.key_match  = rd_q.key == key_q;
		sts.probe_last = cnt_q == LAST;
		sts.have_tomb  = have_tomb_q;
		sts.occ_full   = (occ_q + 1'b1) > {1'b0, max_q};
		sts.out_free   = !out_valid_q || rsp.ready;
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.hit       = out_hit_q;
	assign rsp.value_out = out_val_q;
	assign rsp.rejected  = out_rej_q;

endmodule

`default_nettype wire

// ----- src/open_addressing_hash_table.sv -----
// Open-addressing hash table with linear probing and tombstones.
//
// Channels: req (sink) transfers one request per valid/ready handshake:
// req_type (insert or update, lookup, remove), key_id, key_hash and
// store_value. rsp (source) transfers exactly one result per request: hit,
// value_out and rejected. cfg_we/cfg_wdata write the occupancy limit
// max_occupied (reset 192); write it only while the table is idle.
//
// Timing: one request at a time. After the request transfer the home slot
// unit reduces key_hash (a mask for a power-of-two SLOTS, else a reciprocal
// multiplication), each probed slot is read from the slot memory and then
// checked, and a final step, once the output register is free, writes the
// slot and loads the response register. The probe loop over the slot memory
// sets the throughput.
//
// Reset: the slot memory is swept to empty, one slot a cycle, with req.ready
// low. A stalled rsp holds its result in the output register; the next
// request is still taken and waits before its own write.
// Depends on oaht_pkg, oaht_if, oaht_ctrl, oaht_datapath.
`default_nettype none

module open_addressing_hash_table #(
	parameter int SLOTS = 256
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         cfg_we,
	input  wire  [oaht_pkg::CFG_W-1:0]  cfg_wdata,
	oaht_req_if.sink                    req,
	oaht_rsp_if.source                  rsp
);
	import oaht_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequence clear, probe and finish
	oaht_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	// hold slots, probe state and the response register
	oaht_datapath #(.SLOTS(SLOTS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.rsp       (rsp),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

`default_nettype wire
